FILE: rtl/cbp_pkg.sv
// shared constants, request type and counter update for the correlating branch predictor
// no dependencies
`default_nettype none

package cbp_pkg;

    localparam int ADDR_W    = 32;
    localparam int PC_BITS   = 10;
    localparam int HIST_BITS = 2;
    localparam int IDX_W     = PC_BITS + HIST_BITS;
    localparam int TABLE_DEPTH = 1 << IDX_W;
    localparam int CTR_W     = 2;

    localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'b00;
    localparam logic [CTR_W-1:0] CTR_WEAK_NT   = 2'b01;
    localparam logic [CTR_W-1:0] CTR_WEAK_T    = 2'b10;
    localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'b11;

    // queue depths must be powers of two, pointers wrap on their own
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = Q_PTR_W + 1;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = OQ_PTR_W + 1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             taken;
    } cbp_req_t;

    typedef struct packed {
        logic     valid;
        cbp_req_t req;
    } cbp_link_t;

    function automatic logic [CTR_W-1:0] next_counter(input logic [CTR_W-1:0] c,
                                                      input logic taken);
        logic [CTR_W-1:0] n;
        begin
            if (taken)
            begin
                n = (c == CTR_STRONG_NT) ? CTR_WEAK_NT : CTR_STRONG_T;
            end
            else
            begin
                n = (c == CTR_STRONG_T) ? CTR_WEAK_T : CTR_STRONG_NT;
            end
            return n;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cbp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cbp_front.sv
// front end: global history register and table index formation
// depends on cbp_pkg
`default_nettype none

module cbp_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic [cbp_pkg::ADDR_W-1:0]     branch_address,
    input  wire logic                           actual_taken,
    output cbp_pkg::cbp_link_t                  link
);
    import cbp_pkg::*;

    logic [HIST_BITS-1:0] hist_reg;
    logic [HIST_BITS-1:0] hist_next;

    // the history only depends on outcomes, so it moves ahead at accept time
    always_comb
    begin
        link.valid     = accept;
        link.req.idx   = {branch_address[PC_BITS-1:0], hist_reg};
        link.req.taken = actual_taken;
        hist_next      = hist_reg;
        if (accept)
        begin
            hist_next = HIST_BITS'({hist_reg, actual_taken});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '1;
        end
        else
        begin
            hist_reg <= hist_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cbp_queue.sv
// short request queue between the front end and the table update back end
// depends on cbp_pkg
`default_nettype none

module cbp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cbp_pkg::cbp_link_t in_link,
    output logic                    q_full,
    input  wire logic               deq,
    output cbp_pkg::cbp_link_t      out_link
);
    import cbp_pkg::*;

    cbp_req_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_deq;

    assign q_full         = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign out_link.valid = (count_reg != '0);
    assign out_link.req   = slot_reg[rd_ptr_reg];
    assign do_deq         = deq && out_link.valid;

    always_comb
    begin
        count_next = count_reg;
        if (in_link.valid && !do_deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!in_link.valid && do_deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_link.valid)
        begin
            slot_reg[wr_ptr_reg] <= in_link.req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_link.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/cbp_back.sv
// back end: counter table clear sweep, read-modify-write with bypass, result queue
// depends on cbp_pkg and cbp_ram
`default_nettype none

module cbp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cbp_pkg::cbp_link_t in_link,
    output logic                    deq,
    output logic                    clearing,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    predicted_taken
);
    import cbp_pkg::*;

    logic                 clr_active_reg;
    logic [IDX_W-1:0]     clr_idx_reg;

    logic                 b2_valid_reg;
    cbp_req_t             b2_req_reg;

    logic                 byp_valid_reg;
    logic [IDX_W-1:0]     byp_idx_reg;
    logic [CTR_W-1:0]     byp_ctr_reg;

    logic [CTR_W-1:0]     rdata;
    logic [CTR_W-1:0]     cur_ctr;
    logic [CTR_W-1:0]     new_ctr;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [CTR_W-1:0]     ram_wdata;

    logic                 oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  oq_wr_reg;
    logic [OQ_PTR_W-1:0]  oq_rd_reg;
    logic [OQ_CNT_W-1:0]  oq_count_reg;
    logic [OQ_CNT_W-1:0]  oq_count_next;
    logic [OQ_CNT_W-1:0]  occupancy;
    logic                 do_pop;

    // a request in the update stage already owns a result slot
    assign occupancy = oq_count_reg + OQ_CNT_W'(b2_valid_reg);
    assign deq       = !clr_active_reg && in_link.valid && (occupancy < OQ_CNT_W'(OQ_DEPTH));
    assign clearing  = clr_active_reg;

    // the ram returns old data when read at the edge of the previous write
    assign cur_ctr = (byp_valid_reg && (byp_idx_reg == b2_req_reg.idx)) ? byp_ctr_reg : rdata;
    assign new_ctr = next_counter(cur_ctr, b2_req_reg.taken);

    always_comb
    begin
        ram_we    = clr_active_reg || b2_valid_reg;
        ram_waddr = clr_active_reg ? clr_idx_reg : b2_req_reg.idx;
        ram_wdata = clr_active_reg ? CTR_STRONG_T : new_ctr;
    end

    cbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (deq),
        .raddr (in_link.req.idx),
        .rdata (rdata)
    );

    assign empty           = (oq_count_reg == '0);
    assign predicted_taken = oq_reg[oq_rd_reg];
    assign do_pop          = pop && !empty;

    always_comb
    begin
        oq_count_next = oq_count_reg;
        if (b2_valid_reg && !do_pop)
        begin
            oq_count_next = oq_count_reg + 1'b1;
        end
        else if (!b2_valid_reg && do_pop)
        begin
            oq_count_next = oq_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (deq)
        begin
            b2_req_reg <= in_link.req;
        end
        if (b2_valid_reg)
        begin
            byp_idx_reg        <= b2_req_reg.idx;
            byp_ctr_reg        <= new_ctr;
            oq_reg[oq_wr_reg]  <= cur_ctr[CTR_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            b2_valid_reg   <= 1'b0;
            byp_valid_reg  <= 1'b0;
            oq_wr_reg      <= '0;
            oq_rd_reg      <= '0;
            oq_count_reg   <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            b2_valid_reg  <= deq;
            byp_valid_reg <= b2_valid_reg;
            if (b2_valid_reg)
            begin
                oq_wr_reg <= oq_wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                oq_rd_reg <= oq_rd_reg + 1'b1;
            end
            oq_count_reg <= oq_count_next;
        end
    end

    a_no_issue_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !deq)
        else $error("request issued during table clear");

    a_result_slot_reserved : assert property (@(posedge clk) disable iff (!rst_n)
        (oq_count_reg + OQ_CNT_W'(b2_valid_reg)) <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overcommitted");

    a_bypass_follows_update : assert property (@(posedge clk) disable iff (!rst_n)
        b2_valid_reg |=> (byp_valid_reg && byp_idx_reg == $past(b2_req_reg.idx)))
        else $error("bypass register lost the last counter write");

endmodule

`default_nettype wire

FILE: rtl/correlating_branch_predictor_top.sv
// Correlating (10,2) branch predictor with 2-bit counters. After reset the 4096-entry
// counter table is swept to strongly taken, one entry a cycle, so full stays high
// until the sweep is done. After that one branch request is taken every cycle unless
// the request queue is full: the front end forms the index from the address and the
// global history, a four-entry queue hands it to the back end, which reads the counter
// from the table ram, makes the prediction and writes the updated counter in the cycle
// after the read, with a bypass for back-to-back requests to the same entry. A
// prediction passes the update stage and waits in a four-entry result queue; the single
// read and single write port of the table ram set the rate at one request per cycle.
// depends on cbp_pkg, cbp_front, cbp_queue, cbp_back
`default_nettype none

module correlating_branch_predictor_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [cbp_pkg::ADDR_W-1:0] branch_address,
    input  wire logic                       actual_taken,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            predicted_taken
);
    import cbp_pkg::*;

    cbp_link_t front_link;
    cbp_link_t back_link;
    logic      q_full;
    logic      clearing;
    logic      deq;
    logic      accept;

    assign full   = q_full || clearing;
    assign accept = push && !full;

    cbp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .branch_address (branch_address),
        .actual_taken   (actual_taken),
        .link           (front_link)
    );

    cbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_link  (front_link),
        .q_full   (q_full),
        .deq      (deq),
        .out_link (back_link)
    );

    cbp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_link         (back_link),
        .deq             (deq),
        .clearing        (clearing),
        .empty           (empty),
        .pop             (pop),
        .predicted_taken (predicted_taken)
    );

endmodule

`default_nettype wire

FILE: dv/tb_correlating_branch_predictor_top.sv
// testbench for correlating_branch_predictor_top: drives branch requests, predicts each
// prediction with its own counter table and global history, and checks every result
// depends on cbp_pkg and the rtl of correlating_branch_predictor_top
`timescale 1ns / 1ps

module tb_correlating_branch_predictor_top;
    import cbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_REQUESTS = 900;
    localparam int POOL_SIZE = 8;

    class cbp_scoreboard;
        logic [CTR_W-1:0]     counters [TABLE_DEPTH];
        logic [HIST_BITS-1:0] history;
        logic                 predictions_q[$];
        int                   mismatches;

        function new();
            foreach (counters[i])
            begin
                counters[i] = CTR_STRONG_T;
            end
            history     = '1;
            mismatches  = 0;
        endfunction

        // called for every accepted request, in order of acceptance
        function void note_request(logic [ADDR_W-1:0] addr, logic taken);
            logic [IDX_W-1:0] idx;
            logic [CTR_W-1:0] ctr;
            idx = {addr[PC_BITS-1:0], history};
            ctr = counters[idx];
            predictions_q.push_back(ctr[1]);
            // counter does not saturate by +1/-1: weak states jump to strong
            case (ctr)
                CTR_STRONG_NT: counters[idx] = taken ? CTR_WEAK_NT  : CTR_STRONG_NT;
                CTR_WEAK_NT:   counters[idx] = taken ? CTR_STRONG_T : CTR_STRONG_NT;
                CTR_WEAK_T:    counters[idx] = taken ? CTR_STRONG_T : CTR_STRONG_NT;
                default:       counters[idx] = taken ? CTR_STRONG_T : CTR_WEAK_T;
            endcase
            history = (history << 1) | HIST_BITS'(taken);
        endfunction

        function void check_prediction(logic got);
            logic want;
            if (predictions_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("ERROR: prediction %b popped with no request pending", got);
                mismatches++;
            end
            else
            begin
                want = predictions_q.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("ERROR: predicted_taken expected %b got %b", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return predictions_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [ADDR_W-1:0] branch_address;
    logic              actual_taken;
    logic              empty;
    logic              pop;
    logic              predicted_taken;

    cbp_scoreboard     sb;
    bit                calm;
    int                quiet_cycles;
    logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
    int                pool_bias [POOL_SIZE];

    correlating_branch_predictor_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .branch_address  (branch_address),
        .actual_taken    (actual_taken),
        .empty           (empty),
        .pop             (pop),
        .predicted_taken (predicted_taken)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // result side: random stalls except during the calm stretch
    always @(negedge clk)
    begin
        pop <= calm || ($urandom_range(0, 99) >= 18);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_prediction(predicted_taken);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("correlating_branch_predictor_top regression: fail");
            $finish;
        end
    end

    task automatic send_request(logic [ADDR_W-1:0] addr, logic taken);
        @(negedge clk);
        push           <= 1'b1;
        branch_address <= addr;
        actual_taken   <= taken;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        sb.note_request(addr, taken);
    endtask

    task automatic hold_push_low();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic maybe_idle();
        if (!calm && $urandom_range(0, 99) < 18)
            hold_push_low();
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    task automatic run_directed();
        send_request(32'h0000_0000, 1'b1);
        send_request(32'hFFFF_FFFF, 1'b0);
        // upper address bits are dropped: these share PC bits with the first two requests
        send_request(32'h0000_03FF, 1'b0);
        send_request(32'hFFFF_FC00, 1'b1);
        send_request(32'hA5A5_A000, 1'b0);
        // walk one entry down to strongly not taken at history 00
        repeat (4)
            send_request(32'h0000_0155, 1'b0);
        send_request(32'h8000_0155, 1'b1);
        maybe_idle();
        send_request(32'h0000_02AA, 1'b0);
        send_request(32'h0000_02AA, 1'b0);
        // same entry again, weak not taken to strongly taken
        send_request(32'h7FFF_FD55, 1'b1);
        // alternating outcomes exercise the history shift
        send_request(32'h0000_0001, 1'b1);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0001, 1'b1);
        send_request(32'h0000_0001, 1'b0);
        send_request(32'h0000_0200, 1'b0);
        send_request(32'h0000_0200, 1'b1);
        send_request(32'h5A5A_5DFF, 1'b1);
        send_request(32'h0000_0200, 1'b0);
    endtask

    task automatic run_random();
        int               k;
        logic [ADDR_W-1:0] addr;
        logic              taken;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_addr[i] = $urandom();
            pool_bias[i] = $urandom_range(0, 100);
        end
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            calm = (n >= 300 && n < 500);
            maybe_idle();
            if ($urandom_range(0, 99) < 75)
            begin
                // a few hot branches with biased outcomes keep counters moving
                k     = $urandom_range(0, POOL_SIZE - 1);
                addr  = ADDR_W'({$urandom(), pool_addr[k][PC_BITS-1:0]});
                taken = ($urandom_range(0, 99) < pool_bias[k]);
            end
            else
            begin
                addr  = $urandom();
                taken = 1'($urandom_range(0, 1));
            end
            send_request(addr, taken);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        branch_address = '0;
        actual_taken   = 1'b0;
        calm           = 1'b0;
        quiet_cycles   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        // sender holds off until every prediction has come back
        wait_drained();
        run_random();
        hold_push_low();
        wait_drained();
        repeat (10) @(posedge clk);

        if (sb.mismatches == 0)
            $display("correlating_branch_predictor_top regression: pass");
        else
            $display("correlating_branch_predictor_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cbp_pkg.sv
rtl/cbp_ram.sv
rtl/cbp_front.sv
rtl/cbp_queue.sv
rtl/cbp_back.sv
rtl/correlating_branch_predictor_top.sv
dv/tb_correlating_branch_predictor_top.sv
